### rtl/core/arcseg_pkg.sv
// arc-length segment lookup: shared types and constants
// table geometry, fixed-point widths and the request and result payload structs
// no dependencies
`timescale 1ns / 1ps

package arcseg_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int PARAM_BITS  = 30;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int DIST_W      = 32;
	localparam int PIDX_W      = 16;
	localparam int KIND_W      = 2;
	localparam int PROD_W      = PARAM_BITS + DIST_W;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [9:0]  entry_index;
		logic [31:0] entry_distance;
		logic [15:0] entry_point_index;
		logic [29:0] entry_param;
		logic [1:0]  entry_kind;
		logic [31:0] query_distance;
	} arcseg_req_t;

	typedef struct packed {
		logic [9:0]  found_index;
		logic [15:0] found_point_index;
		logic [1:0]  found_kind;
		logic [29:0] param_out;
		logic        status;
	} arcseg_rsp_t;

	typedef struct packed {
		logic [DIST_W-1:0]     distance;
		logic [PIDX_W-1:0]     pidx;
		logic [PARAM_BITS-1:0] param;
		logic [KIND_W-1:0]     kind;
	} arcseg_entry_t;

endpackage

### rtl/core/arc_length_segment_lookup.sv
// arc-length segment lookup: top level with segment table, search sequencer and serial divider
// depends on arcseg_pkg
`timescale 1ns / 1ps

// Load requests write one table slot in the cycle they are accepted and give no result.
// A query runs under a sequencer against the segment table's single read port: one read to
// clamp the distance to the last entry, a binary search that passes through a search and a
// probe state per step, reads of the found entry and its predecessor, a 30x32 multiply
// and a restoring divider that retires one quotient bit per cycle. The predecessor read is
// skipped when the found entry is the first, and the divider when its span is zero. An
// empty-table query goes from idle straight to the done state. The input side stays ready
// only while the sequencer is idle; a finished result waits in the output register while
// further requests are taken.
module arc_length_segment_lookup
	import arcseg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  arcseg_req_t      in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output arcseg_rsp_t      out_data,
	input  logic             cfg_wen,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLAMP  = 4'd1;
	localparam logic [3:0] S_SEARCH = 4'd2;
	localparam logic [3:0] S_PROBE  = 4'd3;
	localparam logic [3:0] S_FIX    = 4'd4;
	localparam logic [3:0] S_END    = 4'd5;
	localparam logic [3:0] S_PREV   = 4'd6;
	localparam logic [3:0] S_SPAN   = 4'd7;
	localparam logic [3:0] S_MUL    = 4'd8;
	localparam logic [3:0] S_DIV    = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	localparam int DCNT_W = $clog2(PARAM_BITS + 1);

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      seg_count_q;
	logic [CNT_W-1:0]      count_q;
	logic [DIST_W-1:0]     key_q;
	logic [ADDR_W-1:0]     lo_q;
	logic [ADDR_W-1:0]     hi_q;
	logic [ADDR_W-1:0]     mid_q;
	logic [ADDR_W-1:0]     idx_q;
	logic                  empty_q;
	logic [DIST_W-1:0]     end_d_q;
	logic [PARAM_BITS-1:0] end_t_q;
	logic [PIDX_W-1:0]     end_pidx_q;
	logic [KIND_W-1:0]     end_kind_q;
	logic [DIST_W-1:0]     start_d_q;
	logic [PARAM_BITS-1:0] start_t_q;
	logic                  zero_span_q;
	logic                  fall_q;
	logic [DIST_W-1:0]     den_q;
	logic [DIST_W-1:0]     num_q;
	logic [PARAM_BITS-1:0] diff_q;
	logic [DIST_W-1:0]     rem_q;
	logic [PARAM_BITS-1:0] quo_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  out_valid_q;
	arcseg_rsp_t           out_data_q;

	arcseg_entry_t         mem [TABLE_DEPTH];
	arcseg_entry_t         rd_q;
	arcseg_entry_t         wdata;
	logic                  mem_we;
	logic [ADDR_W-1:0]     raddr;

	logic                  accept;
	logic [CNT_W-1:0]      cnt_eff;
	logic [ADDR_W:0]       mid_sum;
	logic [ADDR_W-1:0]     mid;
	logic [ADDR_W-1:0]     idx_next;
	logic [DIST_W-1:0]     den;
	logic [DIST_W-1:0]     num_raw;
	logic [PROD_W-1:0]     prod;
	logic [DIST_W:0]       trial;
	logic [DIST_W:0]       shifted;
	logic                  out_free;
	arcseg_rsp_t           rsp;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cnt_eff = (seg_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : seg_count_q;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[ADDR_W:1];

	assign idx_next = ((rd_q.distance < key_q) && ((CNT_W'(hi_q) + CNT_W'(1)) < count_q))
		? hi_q + ADDR_W'(1) : hi_q;

	assign den     = end_d_q - start_d_q;
	assign num_raw = (key_q > start_d_q) ? key_q - start_d_q : '0;
	assign prod    = PROD_W'(diff_q) * PROD_W'(num_q);

	assign shifted = {rem_q, quo_q[PARAM_BITS-1]};
	assign trial   = shifted - {1'b0, den_q};

	// table write port
	assign mem_we = accept && (in_data.cmd == CMD_LOAD)
		&& (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
	assign wdata.distance = in_data.entry_distance;
	assign wdata.pidx     = in_data.entry_point_index;
	assign wdata.param    = in_data.entry_param;
	assign wdata.kind     = in_data.entry_kind;

	always_comb begin
		unique case (state_q)
			S_IDLE:   raddr = ADDR_W'(cnt_eff - CNT_W'(1));
			S_SEARCH: raddr = (lo_q < hi_q) ? mid : hi_q;
			S_FIX:    raddr = idx_next;
			S_END:    raddr = idx_q - ADDR_W'(1);
			default:  raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ADDR_W'(in_data.entry_index)] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_comb begin
		rsp = '0;
		if (empty_q) begin
			rsp.status = STATUS_EMPTY;
		end else begin
			rsp.status            = STATUS_OK;
			rsp.found_index       = 10'(idx_q);
			rsp.found_point_index = end_pidx_q;
			rsp.found_kind        = end_kind_q;
			if (zero_span_q) begin
				rsp.param_out = 30'(end_t_q);
			end else if (fall_q) begin
				rsp.param_out = 30'(start_t_q - quo_q);
			end else begin
				rsp.param_out = 30'(start_t_q + quo_q);
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seg_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				seg_count_q <= cfg_wdata;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (in_data.cmd == CMD_QUERY)) begin
						state_q <= (cnt_eff == '0) ? S_DONE : S_CLAMP;
					end
				end
				S_CLAMP:  state_q <= S_SEARCH;
				S_SEARCH: state_q <= (lo_q < hi_q) ? S_PROBE : S_FIX;
				S_PROBE:  state_q <= S_SEARCH;
				S_FIX:    state_q <= S_END;
				S_END:    state_q <= (idx_q != '0) ? S_PREV : S_SPAN;
				S_PREV:   state_q <= S_SPAN;
				S_SPAN:   state_q <= S_MUL;
				S_MUL:    state_q <= zero_span_q ? S_DONE : S_DIV;
				S_DIV: begin
					if (dcnt_q == DCNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				count_q <= cnt_eff;
				key_q   <= in_data.query_distance;
				lo_q    <= '0;
				hi_q    <= ADDR_W'(cnt_eff - CNT_W'(1));
				empty_q <= (cnt_eff == '0);
			end
			S_CLAMP: begin
				if (key_q > rd_q.distance) begin
					key_q <= rd_q.distance;
				end
			end
			S_SEARCH: begin
				mid_q <= mid;
			end
			S_PROBE: begin
				if (rd_q.distance < key_q) begin
					lo_q <= mid_q + ADDR_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_FIX: begin
				idx_q <= idx_next;
			end
			S_END: begin
				end_d_q    <= rd_q.distance;
				end_t_q    <= rd_q.param;
				end_pidx_q <= rd_q.pidx;
				end_kind_q <= rd_q.kind;
				start_d_q  <= '0;
				start_t_q  <= '0;
			end
			S_PREV: begin
				start_d_q <= rd_q.distance;
				start_t_q <= (rd_q.pidx == end_pidx_q) ? rd_q.param : '0;
			end
			S_SPAN: begin
				zero_span_q <= (end_d_q <= start_d_q);
				den_q       <= den;
				num_q       <= (num_raw > den) ? den : num_raw;
				fall_q      <= (end_t_q < start_t_q);
				diff_q      <= (end_t_q < start_t_q) ? start_t_q - end_t_q : end_t_q - start_t_q;
			end
			S_MUL: begin
				rem_q  <= prod[PROD_W-1:PARAM_BITS];
				quo_q  <= prod[PARAM_BITS-1:0];
				dcnt_q <= DCNT_W'(PARAM_BITS);
			end
			S_DIV: begin
				if (!trial[DIST_W]) begin
					rem_q <= trial[DIST_W-1:0];
				end else begin
					rem_q <= shifted[DIST_W-1:0];
				end
				quo_q  <= {quo_q[PARAM_BITS-2:0], !trial[DIST_W]};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q <= rsp;
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_div_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (den_q != '0))
		else $error("divide with zero span");

	a_div_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < den_q))
		else $error("partial remainder not below divisor");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH || state_q == S_PROBE) |->
		(lo_q <= hi_q && CNT_W'(hi_q) < count_q))
		else $error("search window out of range");

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.status == STATUS_EMPTY) |->
		(out_data_q.found_index == '0 && out_data_q.param_out == '0))
		else $error("empty-table result carries data");

	a_done_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished query not moved to output");

endmodule

### sim/tb.sv
// testbench for arc_length_segment_lookup: loads segment tables, sets the entry count and
// checks every query result field by field against a table model kept in a scoreboard class
// depends on arcseg_pkg and the arc_length_segment_lookup top level
`timescale 1ns / 1ps

module tb;
	import arcseg_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned RANDOM_TARGET = 950;
	localparam int unsigned MAX_IDLE      = 13;

	localparam logic [KIND_W-1:0] KIND_LINE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUAD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CONIC = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CUBIC = 2'd3;

	class segment_table_model;
		logic [DIST_W-1:0]     seg_dist  [TABLE_DEPTH];
		logic [PIDX_W-1:0]     seg_pidx  [TABLE_DEPTH];
		logic [PARAM_BITS-1:0] seg_param [TABLE_DEPTH];
		logic [KIND_W-1:0]     seg_kind  [TABLE_DEPTH];
		logic [CNT_W-1:0]      seg_count;
		arcseg_rsp_t           expected_lookups [$];
		int unsigned           mismatches;

		function new();
			foreach (seg_dist[i]) begin
				seg_dist[i]  = '0;
				seg_pidx[i]  = '0;
				seg_param[i] = '0;
				seg_kind[i]  = '0;
			end
			seg_count  = '0;
			mismatches = 0;
		endfunction

		function arcseg_rsp_t lookup_segment(logic [DIST_W-1:0] query);
			arcseg_rsp_t       rsp;
			int unsigned       n, lo, hi, mid;
			logic [DIST_W-1:0] key, start_d, end_d;
			logic [63:0]       start_t, end_t, span, offset, t;
			rsp = '0;
			rsp.status = STATUS_OK;
			n = (seg_count > TABLE_DEPTH) ? TABLE_DEPTH : seg_count;
			if (n == 0) begin
				rsp.status = STATUS_EMPTY;
				return rsp;
			end
			key = query;
			if (key > seg_dist[n - 1])
				key = seg_dist[n - 1];
			lo = 0;
			hi = n - 1;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (seg_dist[mid] < key)
					lo = mid + 1;
				else
					hi = mid;
			end
			if (seg_dist[hi] < key && hi + 1 < n)
				hi++;
			end_d   = seg_dist[hi];
			end_t   = 64'(seg_param[hi]);
			start_d = '0;
			start_t = '0;
			if (hi > 0) begin
				start_d = seg_dist[hi - 1];
				if (seg_pidx[hi - 1] == seg_pidx[hi])
					start_t = 64'(seg_param[hi - 1]);
			end
			if (end_d <= start_d) begin
				t = end_t;
			end else begin
				span   = 64'(end_d) - 64'(start_d);
				offset = (key > start_d) ? 64'(key) - 64'(start_d) : 64'd0;
				if (offset > span)
					offset = span;
				if (end_t >= start_t)
					t = start_t + ((end_t - start_t) * offset) / span;
				else
					t = start_t - ((start_t - end_t) * offset) / span;
			end
			rsp.found_index       = hi[ADDR_W-1:0];
			rsp.found_point_index = seg_pidx[hi];
			rsp.found_kind        = seg_kind[hi];
			rsp.param_out         = t[PARAM_BITS-1:0];
			return rsp;
		endfunction

		function void take_request(arcseg_req_t req);
			if (req.cmd == CMD_LOAD) begin
				seg_dist[req.entry_index]  = req.entry_distance;
				seg_pidx[req.entry_index]  = req.entry_point_index;
				seg_param[req.entry_index] = req.entry_param;
				seg_kind[req.entry_index]  = req.entry_kind;
			end else begin
				expected_lookups.push_back(lookup_segment(req.query_distance));
			end
		endfunction

		function void match_result(arcseg_rsp_t got);
			arcseg_rsp_t want;
			if (expected_lookups.size() == 0) begin
				$error("result with no query outstanding: %p", got);
				mismatches++;
				return;
			end
			want = expected_lookups.pop_front();
			if (got.found_index !== want.found_index) begin
				$error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
				mismatches++;
			end
			if (got.found_point_index !== want.found_point_index) begin
				$error("found_point_index: expected %0d, got %0d",
					want.found_point_index, got.found_point_index);
				mismatches++;
			end
			if (got.found_kind !== want.found_kind) begin
				$error("found_kind: expected %0d, got %0d", want.found_kind, got.found_kind);
				mismatches++;
			end
			if (got.param_out !== want.param_out) begin
				$error("param_out: expected 0x%08h, got 0x%08h", want.param_out, got.param_out);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	arcseg_req_t      in_data;
	logic             out_valid;
	logic             out_ready;
	arcseg_rsp_t      out_data;
	logic             cfg_wen;
	logic [CNT_W-1:0] cfg_wdata;

	segment_table_model table_model;
	bit                 sender_steady;
	bit                 receiver_steady;
	int unsigned        random_requests;
	int unsigned        cycle_count = 0;

	arc_length_segment_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_request(input arcseg_req_t req);
		int unsigned gap;
		gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		table_model.take_request(req);
		random_requests++;
	endtask

	task automatic load_entry(input logic [ADDR_W-1:0] slot, input logic [DIST_W-1:0] distance,
			input logic [PIDX_W-1:0] pidx, input logic [PARAM_BITS-1:0] param,
			input logic [KIND_W-1:0] kind);
		arcseg_req_t req;
		req.cmd               = CMD_LOAD;
		req.entry_index       = slot;
		req.entry_distance    = distance;
		req.entry_point_index = pidx;
		req.entry_param       = param;
		req.entry_kind        = kind;
		req.query_distance    = $urandom;
		send_request(req);
	endtask

	task automatic lookup_distance(input logic [DIST_W-1:0] distance);
		arcseg_req_t req;
		req.cmd               = CMD_QUERY;
		req.entry_index       = ADDR_W'($urandom_range(0, TABLE_DEPTH - 1));
		req.entry_distance    = $urandom;
		req.entry_point_index = PIDX_W'($urandom_range(0, 65535));
		req.entry_param       = PARAM_BITS'($urandom_range(0, 30'h3FFF_FFFF));
		req.entry_kind        = KIND_W'($urandom_range(0, 3));
		req.query_distance    = distance;
		send_request(req);
	endtask

	task automatic load_stray_entry(input int unsigned lowest_slot);
		load_entry(ADDR_W'($urandom_range(lowest_slot, TABLE_DEPTH - 1)), $urandom,
			PIDX_W'($urandom_range(0, 65535)), PARAM_BITS'($urandom_range(0, 30'h3FFF_FFFF)),
			KIND_W'($urandom_range(0, 3)));
	endtask

	// drop valid, let every query come back and the sequencer go idle, then write the count
	task automatic set_segment_count(input logic [CNT_W-1:0] value);
		in_valid <= 1'b0;
		while (table_model.expected_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		table_model.seg_count = value;
	endtask

	// fills slots 0 to n-1; mostly rising distances, shared point indexes give chained params
	task automatic build_table(input int unsigned n);
		logic [DIST_W-1:0]     end_dist [TABLE_DEPTH];
		logic [PIDX_W-1:0]     pidx     [TABLE_DEPTH];
		logic [PARAM_BITS-1:0] param    [TABLE_DEPTH];
		logic [63:0]           d, t;
		int unsigned           shape, i, slot, strays;
		bit                    descending;
		shape      = $urandom_range(0, 9);
		descending = ($urandom_range(0, 3) == 0);
		d = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 4096));
		for (i = 0; i < n; i++) begin
			if (i > 0) begin
				case (shape)
					0, 1, 2, 3: d += 64'($urandom_range(1, 300));
					4, 5, 6:    d += 64'($urandom_range(1, 1 << 20));
					7:          d += 64'(($urandom >> $urandom_range(0, 12)) + 1);
					8:          d += 64'($urandom_range(0, 2));
					default:    d = 64'($urandom);
				endcase
			end
			if (d > 64'hFFFF_FFFF)
				d = 64'hFFFF_FFFF;
			end_dist[i] = d[DIST_W-1:0];
			if (i > 0 && $urandom_range(0, 1) == 0) begin
				pidx[i] = pidx[i - 1];
				t = 64'(param[i - 1]);
				if ($urandom_range(0, 3) != 0) begin
					t += 64'($urandom_range(0, 1 << 26));
					if (t > 64'h3FFF_FFFF)
						t = 64'h3FFF_FFFF;
				end else begin
					t = 64'($urandom_range(0, 30'h3FFF_FFFF));
				end
				param[i] = t[PARAM_BITS-1:0];
			end else begin
				pidx[i]  = PIDX_W'($urandom_range(0, 65535));
				param[i] = PARAM_BITS'($urandom_range(0, 30'h3FFF_FFFF));
			end
		end
		for (i = 0; i < n; i++) begin
			slot = descending ? n - 1 - i : i;
			load_entry(ADDR_W'(slot), end_dist[slot], pidx[slot], param[slot],
				KIND_W'($urandom_range(0, 3)));
		end
		strays = (n < TABLE_DEPTH) ? $urandom_range(0, 3) : 0;
		for (i = 0; i < strays; i++)
			load_stray_entry(n);
	endtask

	function automatic logic [DIST_W-1:0] choose_lookup_distance();
		int unsigned       n;
		logic [DIST_W-1:0] at;
		n = (table_model.seg_count > TABLE_DEPTH) ? TABLE_DEPTH : table_model.seg_count;
		if (n == 0)
			return $urandom;
		at = table_model.seg_dist[$urandom_range(0, n - 1)];
		case ($urandom_range(0, 7))
			0:       return $urandom;
			1:       return at;
			2:       return at - $urandom_range(1, 3);
			3:       return at + $urandom_range(1, 3);
			4:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
			default: return $urandom_range(0, table_model.seg_dist[n - 1]);
		endcase
	endfunction

	// result side: random stall before each result, some phases without stalls
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			table_model.match_result(out_data);
		end
	end

	initial begin
		int unsigned      sel, n, q, i, k;
		logic [CNT_W-1:0] count;
		table_model     = new();
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		in_data         = '0;
		cfg_wen         = 1'b0;
		cfg_wdata       = '0;
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		random_requests = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		set_segment_count('0);
		lookup_distance('0);
		lookup_distance('1);

		// zero-length first segment, falling param on a shared point, new point, far end
		load_entry(ADDR_W'(0), 32'h0000_0000, 16'h0000, 30'h3FFF_FFFF, KIND_LINE);
		load_entry(ADDR_W'(1), 32'h0001_0000, 16'h0000, 30'h1000_0000, KIND_QUAD);
		load_entry(ADDR_W'(2), 32'h0003_0000, 16'hFFFF, 30'h3FFF_FFFF, KIND_CONIC);
		load_entry(ADDR_W'(3), 32'hFFFF_FFFF, 16'hFFFF, 30'h0000_0000, KIND_CUBIC);
		load_entry(ADDR_W'(TABLE_DEPTH - 1), 32'hFFFF_FFFF, 16'hFFFF, 30'h3FFF_FFFF, KIND_CUBIC);

		set_segment_count(CNT_W'(1));
		lookup_distance('0);
		lookup_distance('1);

		set_segment_count(CNT_W'(4));
		lookup_distance(32'h0000_0000);
		lookup_distance(32'h0000_8000);
		lookup_distance(32'h0001_0000);
		lookup_distance(32'h0002_0000);
		lookup_distance(32'h0003_0000);
		lookup_distance(32'h8000_0000);
		lookup_distance(32'hFFFF_FFFF);

		// whole table, then counts at and above the depth
		sender_steady = 1'b1;
		build_table(TABLE_DEPTH);
		sender_steady = 1'b0;
		for (i = 0; i < 3; i++) begin
			case (i)
				0:       count = CNT_W'(TABLE_DEPTH);
				1:       count = CNT_W'(TABLE_DEPTH + 1);
				default: count = '1;
			endcase
			set_segment_count(count);
			for (k = 0; k < 8; k++)
				lookup_distance(choose_lookup_distance());
		end

		random_requests = 0;
		while (random_requests < RANDOM_TARGET) begin
			sender_steady   = ($urandom_range(0, 3) == 0);
			receiver_steady = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 19);
			if (sel < 13) begin
				n = $urandom_range(1, 16);
				build_table(n);
				count = CNT_W'(n);
			end else if (sel < 16) begin
				n = $urandom_range(17, 128);
				build_table(n);
				count = CNT_W'(n);
			end else if (sel < 18) begin
				count = CNT_W'($urandom_range(129, 2047));
			end else if (sel == 18) begin
				count = '0;
			end else begin
				build_table($urandom_range(1, 16));
				count = ($urandom_range(0, 1) == 0) ? CNT_W'(TABLE_DEPTH) : '1;
			end
			set_segment_count(count);
			q = $urandom_range(4, 30);
			for (i = 0; i < q; i++) begin
				if ($urandom_range(0, 7) == 0)
					load_stray_entry(0);
				lookup_distance(choose_lookup_distance());
			end
		end

		in_valid <= 1'b0;
		while (table_model.expected_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (table_model.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
